/* hw/rtl/wst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wst_pkg
// Shared types, sizes and helper functions of the wait slot table.
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int PROC_BITS   = 8;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS);

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [PROC_BITS-1:0] proc_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [NRES_W-1:0]    nres_t;

  typedef enum logic [1:0] {
    CMD_WAIT     = 2'd0,
    CMD_POLL     = 2'd1,
    CMD_WAKE_ONE = 2'd2,
    CMD_WAKE_ALL = 2'd3
  } wst_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_WAITING = 2'd2,
    STAT_NONE    = 2'd3
  } wst_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } wst_state_e;

  typedef struct packed {
    wst_cmd_e   cmd;
    logic [7:0] proc_id;
    logic [3:0] slot_index;
  } wst_req_t;

  typedef struct packed {
    wst_status_e status;
    logic [3:0]  out_slot;
    logic [7:0]  out_proc;
    logic [4:0]  waiter_count;
    logic        last;
  } wst_res_t;

  // controller to datapath
  typedef struct packed {
    logic exec_single;
    logic start_all;
    logic scan_step;
  } wst_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic any_valid;
    logic scan_last;
  } wst_stat_t;

  // lowest set bit of a slot mask, zero when empty
  function automatic slot_idx_t lowest_set(slot_mask_t m);
    slot_idx_t idx;
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [4:0] sat_count(cnt_t c);
    logic [4:0] r;
    if (32'(c) > 31) begin
      r = 5'd31;
    end else begin
      r = 5'(c);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/wst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wst_ctrl
// Command controller: takes words, runs the wake-all scan sequence.
// ----------------------------------------------------------------------------
module wst_ctrl
  import wst_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire wst_cmd_e  cmd_i,
  input  wire wst_stat_t stat_i,
  output logic           busy_o,
  output wst_ctrl_t      ctrl_o
);

  wst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // wake-all with waiters present goes through the scan
          if (cmd_i == CMD_WAKE_ALL && stat_i.any_valid) begin
            ctrl_o.start_all = 1'b1;
            state_d          = S_SCAN;
          end else begin
            ctrl_o.exec_single = 1'b1;
          end
        end
      end
      S_SCAN: begin
        busy_o           = 1'b1;
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/wst_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wst_datapath
// Slot table, occupancy count, wake-all scan mask and result register.
// ----------------------------------------------------------------------------
module wst_datapath
  import wst_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire wst_req_t  req_i,
  input  wire wst_ctrl_t ctrl_i,
  output wst_stat_t      stat_o,
  output logic           res_valid_o,
  output wst_res_t       res_o
);

  slot_mask_t valid_q, valid_d;
  slot_mask_t woken_q, woken_d;
  slot_mask_t mask_q, mask_d;
  cnt_t       count_q, count_d;
  nres_t      nres_q, nres_d;
  proc_t      owner_q [NUM_SLOTS];
  logic       owner_we;
  slot_idx_t  owner_wa;
  wst_res_t   res_q, res_d;
  logic       res_valid_q, res_valid_d;

  slot_mask_t free_mask, wake_mask, scan_rest;
  slot_idx_t  free_idx, wake_idx, scan_idx, poll_idx;
  logic       poll_in_range, scan_last;

  assign free_mask     = ~valid_q;
  assign wake_mask     = valid_q & ~woken_q;
  assign free_idx      = lowest_set(free_mask);
  assign wake_idx      = lowest_set(wake_mask);
  assign scan_idx      = lowest_set(mask_q);
  // drop the lowest pending slot
  assign scan_rest     = mask_q & (mask_q - slot_mask_t'(1));
  assign poll_idx      = SLOT_W'(req_i.slot_index);
  assign poll_in_range = 32'(req_i.slot_index) < NUM_SLOTS;
  assign scan_last     = (scan_rest == '0) || (nres_q == NRES_W'(MAX_RESULTS - 1));

  assign stat_o.any_valid = |valid_q;
  assign stat_o.scan_last = scan_last;

  always_comb begin
    valid_d     = valid_q;
    woken_d     = woken_q;
    mask_d      = mask_q;
    count_d     = count_q;
    nres_d      = nres_q;
    owner_we    = 1'b0;
    owner_wa    = free_idx;
    res_d       = '0;
    res_valid_d = 1'b0;

    if (ctrl_i.exec_single) begin
      res_valid_d = 1'b1;
      res_d.last  = 1'b1;
      case (req_i.cmd)
        CMD_WAIT: begin
          if (|free_mask) begin
            valid_d[free_idx] = 1'b1;
            woken_d[free_idx] = 1'b0;
            owner_we          = 1'b1;
            count_d           = count_q + cnt_t'(1);
            res_d.status      = STAT_OK;
            res_d.out_slot    = 4'(free_idx);
          end else begin
            res_d.status = STAT_FULL;
          end
        end
        CMD_POLL: begin
          res_d.out_slot = req_i.slot_index;
          if (!poll_in_range || !valid_q[poll_idx]) begin
            res_d.status = STAT_NONE;
          end else if (woken_q[poll_idx]) begin
            valid_d[poll_idx] = 1'b0;
            woken_d[poll_idx] = 1'b0;
            if (count_q != '0) begin
              count_d = count_q - cnt_t'(1);
            end
            res_d.status = STAT_OK;
          end else begin
            res_d.status = STAT_WAITING;
          end
        end
        CMD_WAKE_ONE: begin
          if (|wake_mask) begin
            woken_d[wake_idx] = 1'b1;
            res_d.status      = STAT_OK;
            res_d.out_slot    = 4'(wake_idx);
            res_d.out_proc    = 8'(owner_q[wake_idx]);
          end else begin
            res_d.status = STAT_NONE;
          end
        end
        default: begin
          // wake-all on an empty table
          res_d.status = STAT_NONE;
        end
      endcase
    end

    if (ctrl_i.start_all) begin
      woken_d = woken_q | valid_q;
      mask_d  = valid_q;
      nres_d  = '0;
    end

    if (ctrl_i.scan_step) begin
      res_valid_d    = 1'b1;
      res_d.status   = STAT_OK;
      res_d.out_slot = 4'(scan_idx);
      res_d.out_proc = 8'(owner_q[scan_idx]);
      res_d.last     = scan_last;
      mask_d         = scan_rest;
      nres_d         = nres_q + nres_t'(1);
    end

    res_d.waiter_count = sat_count(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      woken_q     <= '0;
      mask_q      <= '0;
      count_q     <= '0;
      nres_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      woken_q     <= woken_d;
      mask_q      <= mask_d;
      count_q     <= count_d;
      nres_q      <= nres_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (owner_we) begin
      owner_q[owner_wa] <= PROC_BITS'(req_i.proc_id);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

/* hw/rtl/wait_slot_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wait_slot_table_core
// Waiter slot table with wait, poll, wake-one and wake-all commands.
// ----------------------------------------------------------------------------
//   channel   ports                        handshake
//   command   start, busy, req_i           taken when start && !busy
//   result    res_valid_o, res_o           one-cycle strobe, no back-pressure
//
// wait, poll and wake-one leave busy low, so a new word is taken every
// cycle; the result is registered and follows in the cycle after the word.
// wake-all gives n results for n valid slots (at most 16);
// busy is high while the scan emits one slot per cycle through the
// priority encoder over the pending mask.
// reset clears all marks, the count and the strobe; no clearing pass.
module wait_slot_table_core
  import wst_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire wst_req_t req_i,
  output logic          res_valid_o,
  output wst_res_t      res_o
);

  wst_ctrl_t ctrl;
  wst_stat_t stat;

  wst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (req_i.cmd),
    .stat_i (stat),
    .busy_o (busy),
    .ctrl_o (ctrl)
  );

  wst_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // a full table always reports every slot occupied
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == STAT_FULL |-> res_o.waiter_count == sat_count(cnt_t'(NUM_SLOTS)))
    else $error("full status with wrong waiter count");

  // scan words come back to back until last
  a_scan_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o)
    else $error("gap in wake-all results");

  // leaving the scan coincides with the last word
  a_scan_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.last)
    else $error("scan ended without last word");

  // no word without a command or scan behind it
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy) || $past(busy))
    else $error("result word without a cause");

endmodule
`default_nettype wire
